// ===== hw/rtl/ufr_pkg.sv =====
// Shared types, constants and register codes for the UART frame receiver.
`default_nettype none

package ufr_pkg;

   // Parameter defaults
   localparam int COUNT_WIDTH_DEF   = 24;
   localparam int MAX_DATA_BITS_DEF = 9;

   // Register field widths
   localparam int PERIOD_W = 24;
   localparam int DBITS_W  = 4;
   localparam int STATUS_W = 2;

   // CSR bus
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
   localparam logic [1:0] REG_DATA_BITS  = 2'd1;
   localparam logic [1:0] REG_FRAME_LEN  = 2'd2;

   // Register reset values
   localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = PERIOD_W'(104);
   localparam logic [DBITS_W-1:0]  DATA_BITS_RST  = DBITS_W'(8);
   localparam logic [PERIOD_W-1:0] FRAME_LEN_RST  = PERIOD_W'(1031);

   // Frame status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_START = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_STOP  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERRUN  = 2'd3;

   typedef struct packed {
      logic [PERIOD_W-1:0] bit_period;
      logic [DBITS_W-1:0]  data_bits;
      logic [PERIOD_W-1:0] frame_len;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ufr_csr.sv =====
// Configuration registers behind the APB-style port.
`default_nettype none

module ufr_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ufr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ufr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [ufr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                           csr_pready,
   output      ufr_pkg::cfg_type               cfg
);
   import ufr_pkg::*;

   cfg_type    cfg_ff;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period <= BIT_PERIOD_RST;
         cfg_ff.data_bits  <= DATA_BITS_RST;
         cfg_ff.frame_len  <= FRAME_LEN_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_BIT_PERIOD: cfg_ff.bit_period <= csr_pwdata[PERIOD_W-1:0];
            REG_DATA_BITS:  cfg_ff.data_bits  <= csr_pwdata[DBITS_W-1:0];
            REG_FRAME_LEN:  cfg_ff.frame_len  <= csr_pwdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_BIT_PERIOD: csr_prdata = CSR_DATA_W'(cfg_ff.bit_period);
         REG_DATA_BITS:  csr_prdata = CSR_DATA_W'(cfg_ff.data_bits);
         REG_FRAME_LEN:  csr_prdata = CSR_DATA_W'(cfg_ff.frame_len);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ufr_core.sv =====
// Frame tracker: tick counter, bit sampler and frame-end result logic.
`default_nettype none

module ufr_core #(
   parameter int COUNT_WIDTH   = ufr_pkg::COUNT_WIDTH_DEF,
   parameter int MAX_DATA_BITS = ufr_pkg::MAX_DATA_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ufr_pkg::cfg_type             cfg,
   input  wire logic                         accept,
   input  wire logic                         rx_level,
   output      logic                         res_valid,
   output      logic [MAX_DATA_BITS-1:0]     res_data,
   output      logic [ufr_pkg::STATUS_W-1:0] res_status
);
   import ufr_pkg::*;

   localparam int BI_W = $clog2(MAX_DATA_BITS + 3);
   localparam int SW_W = MAX_DATA_BITS;

   logic                   recv_ff, recv_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0] nst_ff, nst_in;
   logic [BI_W-1:0]        bi_ff, bi_in;
   logic [SW_W-1:0]        sw_ff, sw_in;
   logic [STATUS_W-1:0]    err_ff, err_in;
   logic                   last_ff;

   logic [COUNT_WIDTH-1:0] period, flen;
   logic [BI_W-1:0]        nb;
   logic [BI_W:0]          nb_p1;
   logic                   start, active, hit, frame_end;
   logic [BI_W-1:0]        k;
   logic [SW_W:0]          ones;
   logic [SW_W-1:0]        fill;
   logic [SW_W-1:0]        final_word;
   logic [STATUS_W-1:0]    final_err;

   assign period = COUNT_WIDTH'(cfg.bit_period);
   assign flen   = COUNT_WIDTH'(cfg.frame_len);

   // data_bits clipped to the shift register size
   assign nb    = ({1'b0, cfg.data_bits} > 5'(MAX_DATA_BITS)) ?
                  BI_W'(MAX_DATA_BITS) : BI_W'(cfg.data_bits);
   assign nb_p1 = {1'b0, nb} + 1'b1;

   always_comb begin
      start  = !recv_ff && last_ff && !rx_level;
      active = recv_ff || start;

      // tick bookkeeping
      if (start) begin
         tick_in = '0;
         nst_in  = period >> 1;
         bi_in   = '0;
         sw_in   = '0;
         err_in  = ST_OK;
      end else begin
         tick_in = recv_ff ? tick_ff + 1'b1 : tick_ff;
         nst_in  = nst_ff;
         bi_in   = bi_ff;
         sw_in   = sw_ff;
         err_in  = err_ff;
      end

      // scheduled sample: start bit, data bits LSB first, stop bit
      hit = active && (tick_in == nst_in) && ({1'b0, bi_in} <= nb_p1);
      if (hit) begin
         if (bi_in == '0) begin
            if (rx_level && err_in == ST_OK) err_in = ST_NO_START;
         end else if (bi_in <= nb) begin
            sw_in = (sw_in >> 1) | (SW_W'(rx_level) << (nb - 1'b1));
         end else begin
            if (!rx_level && err_in == ST_OK) err_in = ST_NO_STOP;
         end
         bi_in  = bi_in + 1'b1;
         nst_in = nst_in + period;
      end

      // pending data bits at frame end read as ones
      k          = (bi_in != '0 && bi_in <= nb) ? nb - bi_in + 1'b1 : '0;
      ones       = ~({(SW_W+1){1'b1}} << k);
      fill       = SW_W'(ones << (nb - k));
      final_word = (sw_in >> k) | fill;
      final_err  = (err_in != ST_OK) ? err_in :
                   (bi_in == '0) ? ST_NO_START : ST_OK;

      frame_end = active && (tick_in == flen);
      recv_in   = active && !frame_end;

      res_valid = accept && frame_end;
      if (!rx_level) begin
         res_status = ST_OVERRUN;
         res_data   = '0;
      end else begin
         res_status = final_err;
         res_data   = (final_err == ST_OK) ? final_word : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recv_ff <= 1'b0;
         tick_ff <= '0;
         nst_ff  <= '0;
         bi_ff   <= '0;
         sw_ff   <= '0;
         err_ff  <= ST_OK;
         last_ff <= 1'b1;
      end else if (accept) begin
         recv_ff <= recv_in;
         tick_ff <= tick_in;
         nst_ff  <= nst_in;
         bi_ff   <= bi_in;
         sw_ff   <= sw_in;
         err_ff  <= err_in;
         last_ff <= rx_level;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ufr_out.sv =====
// Result register with one skid slot.
`default_nettype none

module ufr_out #(
   parameter int DATA_W = ufr_pkg::MAX_DATA_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         res_valid,
   input  wire logic [DATA_W-1:0]            res_data,
   input  wire logic [ufr_pkg::STATUS_W-1:0] res_status,
   output      logic                         full,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [DATA_W-1:0]            rsp_data_word,
   output      logic [ufr_pkg::STATUS_W-1:0] rsp_frame_status
);
   import ufr_pkg::*;

   logic                out_vld_ff;
   logic [DATA_W-1:0]   out_data_ff;
   logic [STATUS_W-1:0] out_st_ff;
   logic                skid_vld_ff;
   logic [DATA_W-1:0]   skid_data_ff;
   logic [STATUS_W-1:0] skid_st_ff;
   logic                open;

   assign open             = !out_vld_ff || !rsp_stall;
   assign full             = skid_vld_ff;
   assign rsp_valid        = out_vld_ff;
   assign rsp_data_word    = out_data_ff;
   assign rsp_frame_status = out_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (open) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff  <= res_valid;
         end
      end else if (res_valid) begin
         skid_vld_ff <= 1'b1;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (open) begin
         out_data_ff <= skid_vld_ff ? skid_data_ff : res_data;
         out_st_ff   <= skid_vld_ff ? skid_st_ff : res_status;
      end
      if (!open && res_valid) begin
         skid_data_ff <= res_data;
         skid_st_ff   <= res_status;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/uart_frame_receiver.sv =====
// Top level of the 8N1-style UART frame receiver.
`default_nettype none

// One receive-line sample is taken as a beat on the req_ channel every cycle
// the block is not stalling, so the sustained rate is one sample per clock.
// A falling edge while idle starts a frame; the start bit is checked at half
// a bit period, data bits are shifted in LSB first every bit period, then the
// stop bit is checked. When the tick count since the edge reaches the frame
// length register, one result beat (data_word, frame_status) is produced; it
// is registered in the result register, or in the skid slot while that one
// is stalled. The result register plus one skid slot let sampling continue
// while a result waits; req_stall rises only when both slots hold undelivered
// results. All timing is set by the tick counter and its compare against the
// bit period and frame length registers; software programs those in samples.

module uart_frame_receiver #(
   parameter int COUNT_WIDTH   = ufr_pkg::COUNT_WIDTH_DEF,
   parameter int MAX_DATA_BITS = ufr_pkg::MAX_DATA_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // sample channel
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic                           req_rx_level,
   // result channel
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [MAX_DATA_BITS-1:0]       rsp_data_word,
   output      logic [ufr_pkg::STATUS_W-1:0]   rsp_frame_status,
   // configuration
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ufr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ufr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [ufr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                           csr_pready
);
   import ufr_pkg::*;

   cfg_type                cfg;
   logic                   accept;
   logic                   res_valid;
   logic [MAX_DATA_BITS-1:0] res_data;
   logic [STATUS_W-1:0]    res_status;
   logic                   out_full;

   // Stall only when result register and skid slot are both occupied.
   assign req_stall = out_full;
   assign accept    = req_valid && !req_stall;

   ufr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Per-sample frame tracking; result computed in the same cycle.
   ufr_core #(
      .COUNT_WIDTH   (COUNT_WIDTH),
      .MAX_DATA_BITS (MAX_DATA_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .rx_level   (req_rx_level),
      .res_valid  (res_valid),
      .res_data   (res_data),
      .res_status (res_status)
   );

   // Output register and skid slot.
   ufr_out #(
      .DATA_W (MAX_DATA_BITS)
   ) u_out (
      .clock            (clock),
      .reset            (reset),
      .res_valid        (res_valid),
      .res_data         (res_data),
      .res_status       (res_status),
      .full             (out_full),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_word    (rsp_data_word),
      .rsp_frame_status (rsp_frame_status)
   );

endmodule

`default_nettype wire
